// ===== hw/rtl/watchdog_restart_storm_guard_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the restart storm guard
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WATCHDOG_RESTART_STORM_GUARD_ASSERT_SVH
`define WATCHDOG_RESTART_STORM_GUARD_ASSERT_SVH

// same-cycle implication
`define WRSG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wrsg assertion failed");

// next-cycle implication
`define WRSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wrsg assertion failed");

`endif

// ===== hw/rtl/wrsg_pkg.sv =====
// ----------------------------------------------------------------------------
// wrsg_pkg
// Types and constants of the restart storm guard.
// ----------------------------------------------------------------------------
package wrsg_pkg;

  localparam int unsigned WINDOW_S      = 60;
  localparam int unsigned STALE_DEFAULT = 30;
  localparam int unsigned LIMIT_DEFAULT = 5;

  localparam int unsigned STALE_W  = 16;
  localparam int unsigned LIMIT_W  = 10;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned RECENT_W = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STALE_TIMEOUT = 1'b0,
    REG_MAX_RESTARTS  = 1'b1
  } reg_idx_t;

  typedef enum logic {
    OP_CHECK  = 1'b0,
    OP_RECORD = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ACT_HEALTHY = 2'd0,
    ACT_STOP    = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_BACKOFF = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_DRAIN = 2'd2,
    ST_FIN   = 2'd3
  } state_t;

endpackage

// ===== hw/rtl/wrsg_ram.sv =====
// ----------------------------------------------------------------------------
// wrsg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wrsg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/watchdog_restart_storm_guard.sv =====
// ----------------------------------------------------------------------------
// watchdog_restart_storm_guard
// Supervisor decision block with a sliding 60 s restart rate limiter.
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | payload
//  in_     | in  | in_tvalid / in_tready   | in_tdata (check fields), in_tuser (op)
//  out_    | out | out_tvalid / out_tready | out_tdata (action, kill, count)
//  cfg_    | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
//  A record beat goes from idle straight to the final state; a check beat scans
//  the timestamp RAM through its single read port one entry a cycle, then
//  passes the drain state to the final state, or skips the scan with an empty
//  ring. Input beats are taken only in idle. Reset clears control state; the
//  RAM needs no clearing, only written entries are ever read. A stalled output
//  holds its beat while the next input beat is taken; the finished result then
//  waits in the final state until the output register frees up.
// ----------------------------------------------------------------------------
module watchdog_restart_storm_guard #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: now_s[31:0], agent_alive[32], heartbeat_time[64:33],
  //           stop_requested[65], zero[71:66]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [wrsg_pkg::IN_DATA_W-1:0] in_tdata,
  // in_tuser: op[0]
  input  logic        in_tuser,
  // out_tdata: action[1:0], kill_first[2], recent_restarts[9:3], zero[15:10]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [wrsg_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [wrsg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wrsg_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);

  // input field unpack
  logic [wrsg_pkg::TIME_W-1:0] in_now;
  logic [wrsg_pkg::TIME_W-1:0] in_hb;
  logic                        in_alive;
  logic                        in_stop;
  assign in_now   = in_tdata[31:0];
  assign in_alive = in_tdata[32];
  assign in_hb    = in_tdata[64:33];
  assign in_stop  = in_tdata[65];

  // configuration registers
  logic [wrsg_pkg::STALE_W-1:0] stale_r;
  logic [wrsg_pkg::LIMIT_W-1:0] limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_r <= wrsg_pkg::STALE_W'(wrsg_pkg::STALE_DEFAULT);
      limit_r <= wrsg_pkg::LIMIT_W'(wrsg_pkg::LIMIT_DEFAULT);
    end else if (cfg_valid) begin
      case (wrsg_pkg::reg_idx_t'(cfg_index))
        wrsg_pkg::REG_STALE_TIMEOUT: stale_r <= cfg_data;
        wrsg_pkg::REG_MAX_RESTARTS:  limit_r <= cfg_data[wrsg_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  wrsg_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] head_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] cnt_r;
  logic          pend_r;
  logic          out_tvalid_r;

  // latched beat payload
  logic                        op_r;
  logic [wrsg_pkg::TIME_W-1:0] now_r;
  logic                        alive_r;
  logic                        stop_r;
  logic                        fresh_r;
  logic [wrsg_pkg::OUT_DATA_W-1:0] out_tdata_r;

  logic in_acc;
  logic scan_last;
  logic out_load;
  logic ram_re;
  logic ram_we;
  logic [wrsg_pkg::TIME_W-1:0] ram_rdata;

  assign in_acc    = in_tvalid && in_tready;
  assign scan_last = (idx_r == count_r - CW'(1));

  // heartbeat freshness, judged on the incoming beat
  logic [wrsg_pkg::STALE_W-1:0] stale_lim;
  logic [wrsg_pkg::TIME_W-1:0]  hb_age;
  logic                         in_fresh;
  assign stale_lim = (stale_r == '0) ? wrsg_pkg::STALE_W'(wrsg_pkg::STALE_DEFAULT) : stale_r;
  assign hb_age    = in_now - in_hb;
  assign in_fresh  = !(in_alive && (in_hb != '0)) ||
                     (hb_age <= wrsg_pkg::TIME_W'(stale_lim));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wrsg_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (wrsg_pkg::op_t'(in_tuser) == wrsg_pkg::OP_RECORD || count_r == '0) begin
            state_nxt = wrsg_pkg::ST_FIN;
          end else begin
            state_nxt = wrsg_pkg::ST_SCAN;
          end
        end
      end
      wrsg_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_nxt = wrsg_pkg::ST_DRAIN;
        end
      end
      wrsg_pkg::ST_DRAIN: state_nxt = wrsg_pkg::ST_FIN;
      wrsg_pkg::ST_FIN: begin
        if (out_load) begin
          state_nxt = wrsg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wrsg_pkg::ST_IDLE;
    endcase
  end

  // state-driven controls
  always_comb begin
    in_tready = 1'b0;
    ram_re    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      wrsg_pkg::ST_IDLE:  in_tready = 1'b1;
      wrsg_pkg::ST_SCAN:  ram_re    = 1'b1;
      wrsg_pkg::ST_DRAIN: ;
      wrsg_pkg::ST_FIN:   out_load  = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  assign ram_we = in_acc && (wrsg_pkg::op_t'(in_tuser) == wrsg_pkg::OP_RECORD);

  wrsg_ram #(
    .WIDTH (wrsg_pkg::TIME_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_r),
    .wdata (in_now),
    .re    (ram_re),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // window hit on the entry read last cycle
  logic [wrsg_pkg::TIME_W-1:0] entry_age;
  logic                        hit;
  assign entry_age = now_r - ram_rdata;
  assign hit       = pend_r && (entry_age < wrsg_pkg::TIME_W'(wrsg_pkg::WINDOW_S));

  // decision
  logic [8:0]                    cnt_ext;
  logic [wrsg_pkg::RECENT_W-1:0] recent;
  logic                          under_lim;
  wrsg_pkg::act_t                act;
  logic                          kill;

  assign cnt_ext   = 9'(cnt_r);
  assign recent    = (cnt_ext > 9'd127) ? 7'd127 : cnt_ext[6:0];
  assign under_lim = (limit_r == '0) || (10'(cnt_r) < limit_r);

  always_comb begin
    act  = wrsg_pkg::ACT_HEALTHY;
    kill = 1'b0;
    if (op_r) begin
      act = wrsg_pkg::ACT_HEALTHY;
    end else if (stop_r) begin
      act = wrsg_pkg::ACT_STOP;
    end else if (alive_r && fresh_r) begin
      act = wrsg_pkg::ACT_HEALTHY;
    end else if (under_lim) begin
      act  = wrsg_pkg::ACT_RESTART;
      kill = alive_r;
    end else begin
      act = wrsg_pkg::ACT_BACKOFF;
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wrsg_pkg::ST_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      idx_r        <= '0;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= ram_re;
      if (in_acc) begin
        idx_r <= '0;
        cnt_r <= '0;
      end else begin
        if (ram_re) begin
          idx_r <= idx_r + CW'(1);
        end
        if (hit) begin
          cnt_r <= cnt_r + CW'(1);
        end
      end
      if (ram_we) begin
        head_r <= (head_r == AW'(RING_DEPTH - 1)) ? '0 : head_r + AW'(1);
        if (count_r != CW'(RING_DEPTH)) begin
          count_r <= count_r + CW'(1);
        end
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_tuser;
      now_r   <= in_now;
      alive_r <= in_alive;
      stop_r  <= in_stop;
      fresh_r <= in_fresh;
    end
    if (out_load) begin
      out_tdata_r <= {6'b0, (op_r ? 7'd0 : recent), kill, act};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== hw/rtl/wrsg_checker.sv =====
// ----------------------------------------------------------------------------
// wrsg_checker
// Port-level assertions for the restart storm guard, bound to the top level.
// ----------------------------------------------------------------------------
`include "watchdog_restart_storm_guard_assert.svh"

module wrsg_checker #(
  parameter int unsigned RING_DEPTH = 64
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [wrsg_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned MAX_RECENT = (RING_DEPTH > 127) ? 127 : RING_DEPTH;

  logic out_stall;
  logic out_restart;
  assign out_stall   = out_tvalid && !out_tready;
  assign out_restart = (out_tdata[1:0] == wrsg_pkg::ACT_RESTART);

  // a stalled result beat holds
  `WRSG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_tdata))

  // kill only ever accompanies a restart
  `WRSG_ASSERT_NOW(a_kill_restart, clk, rst_n, out_tvalid && out_tdata[2], out_restart)

  // block drops in_tready in the cycle after it takes a beat
  `WRSG_ASSERT_NEXT(a_busy_after_acc, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // recent count never exceeds the ring depth
  `WRSG_ASSERT_NOW(a_recent_range, clk, rst_n, out_tvalid, out_tdata[9:3] <= 7'(MAX_RECENT))

endmodule

bind watchdog_restart_storm_guard wrsg_checker #(.RING_DEPTH(RING_DEPTH)) u_wrsg_checker (.*);
